// ===== rtl/rlgr1_entropy_encoder_top_macros.svh =====
// Assertion macros for the RLGR1 entropy encoder.
// Included by rlgr1_entropy_encoder_top; no other dependencies.
`ifndef RLGR1_ENTROPY_ENCODER_TOP_MACROS_SVH
`define RLGR1_ENTROPY_ENCODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define RLGR1_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rlgr1 encoder check failed");
// Next-cycle implication
`define RLGR1_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rlgr1 encoder check failed");
`else
`define RLGR1_ASSERT_IMP(label, ck, rn, ante, cons)
`define RLGR1_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif

`endif

// ===== rtl/rlgr1_pkg.sv =====
// Shared types, constants and parameter-update helpers for the RLGR1 encoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rlgr1_pkg;

    localparam int COEFF_W    = 16;
    localparam int RUN_W      = 16;
    localparam int LIT_W      = 12;
    localparam int LLEN_W     = 4;
    localparam int PARAM_W    = 7;
    localparam int ZC_W       = 10;
    localparam int K_W        = 4;
    localparam int OUTQ_DEPTH = 3;
    localparam int QCNT_W     = 2;

    typedef logic [PARAM_W-1:0] param_t;

    localparam param_t PARAM_MAX   = 7'd80;
    localparam param_t PARAM_RESET = 7'd8;
    localparam param_t RUN_UP      = 7'd4;
    localparam param_t RUN_DOWN    = 7'd6;
    localparam param_t GR_UP       = 7'd3;
    localparam param_t GR_DOWN     = 7'd3;
    localparam param_t RICE_DOWN   = 7'd2;
    localparam logic [K_W-1:0] K_MAX = 4'd10;

    typedef struct packed {
        logic               run_bit;
        logic [RUN_W-1:0]   run_length;
        logic [LIT_W-1:0]   literal_bits;
        logic [LLEN_W-1:0]  literal_length;
        logic               final_segment;
    } seg_t;

    typedef struct packed {
        param_t             run_param;
        param_t             rice_param;
        logic [ZC_W-1:0]    zcount;
    } state_t;

    localparam state_t STATE_RESET = '{
        run_param:  PARAM_RESET,
        rice_param: PARAM_RESET,
        zcount:     '0
    };

    // Shift amount from an adaptive parameter (parameter / 8, capped)
    function automatic logic [K_W-1:0] k_of(input param_t p);
        logic [K_W-1:0] k;
        k = p[PARAM_W-1:3];
        return (k > K_MAX) ? K_MAX : k;
    endfunction

    // Add and clamp to the top of the range
    function automatic param_t param_up(input param_t p, input param_t d);
        logic [PARAM_W:0] sum;
        sum = {1'b0, p} + {1'b0, d};
        return (sum > {1'b0, PARAM_MAX}) ? PARAM_MAX : sum[PARAM_W-1:0];
    endfunction

    // Subtract and clamp at zero
    function automatic param_t param_down(input param_t p, input param_t d);
        return (p > d) ? (p - d) : '0;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rlgr1_core.sv =====
// Combinational coding step: one coefficient plus current state gives up to
// two segments and the next state. Depends on rlgr1_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlgr1_core
    import rlgr1_pkg::*;
#(
    parameter int COEFF_BITS = 16
)
(
    input  logic [COEFF_W-1:0] coefficient,
    input  logic               last,
    input  state_t             state,
    output seg_t               seg0,
    output seg_t               seg1,
    output logic [1:0]         nres,
    output state_t             state_next
);

    localparam int CB = COEFF_BITS;

    logic [CB-1:0]    raw;
    logic [CB-1:0]    mag;
    logic [CB-1:0]    ms;
    logic [CB-1:0]    gr_v;
    logic [CB-1:0]    vk;
    logic             neg;
    logic             is_zero;
    logic             run_mode;
    logic             hit;
    logic [K_W-1:0]   k;
    logic [K_W-1:0]   kr;
    logic [ZC_W-1:0]  cnt;
    logic [ZC_W:0]    cnt_inc;
    logic [ZC_W:0]    run_limit;
    logic [LIT_W-1:0] v_lit;
    seg_t             gr_seg;
    param_t           rice_after;

    always_comb
    begin
        raw      = coefficient[CB-1:0];
        neg      = raw[CB-1];
        mag      = neg ? (~raw + 1'b1) : raw;
        // magnitude-sign value; the most negative input maps to all ones
        ms       = neg ? ({mag[CB-2:0], 1'b0} - 1'b1) : {mag[CB-2:0], 1'b0};
        k        = k_of(state.run_param);
        kr       = k_of(state.rice_param);
        run_mode = (k != '0);
        is_zero  = (mag == '0);

        // Golomb-Rice code, shared by both modes
        gr_v  = run_mode ? (is_zero ? '0 : (mag - 1'b1)) : ms;
        vk    = gr_v >> kr;
        v_lit = LIT_W'(gr_v) & ((LIT_W'(1) << kr) - LIT_W'(1));
        gr_seg.run_bit        = 1'b1;
        gr_seg.run_length     = RUN_W'(vk);
        gr_seg.literal_bits   = v_lit;
        gr_seg.literal_length = kr + 4'd1;
        gr_seg.final_segment  = 1'b0;

        if (vk == '0)
        begin
            rice_after = param_down(state.rice_param, RICE_DOWN);
        end
        else if (vk > CB'(1))
        begin
            rice_after = param_up(state.rice_param,
                                  (vk >= CB'(PARAM_MAX)) ? PARAM_MAX : vk[PARAM_W-1:0]);
        end
        else
        begin
            rice_after = state.rice_param;
        end

        // Zero-run bookkeeping
        cnt       = state.zcount & ((ZC_W'(1) << k) - ZC_W'(1));
        cnt_inc   = {1'b0, state.zcount} + 1'b1;
        run_limit = {{ZC_W{1'b0}}, 1'b1} << k;
        hit       = (cnt_inc >= run_limit);

        seg0       = '0;
        seg1       = '0;
        nres       = 2'd0;
        state_next = state;

        if (run_mode)
        begin
            if (is_zero && !last)
            begin
                if (hit)
                begin
                    // escape: a single 0 bit, raise k
                    seg0.run_length      = RUN_W'(1);
                    nres                 = 2'd1;
                    state_next.zcount    = '0;
                    state_next.run_param = param_up(state.run_param, RUN_UP);
                end
                else
                begin
                    state_next.zcount = cnt_inc[ZC_W-1:0];
                end
            end
            else
            begin
                // end of run: 1, count in k bits, sign; then the GR code
                seg0.literal_bits    = (LIT_W'(1) << (k + 4'd1)) | LIT_W'({cnt, neg});
                seg0.literal_length  = k + 4'd2;
                seg1                 = gr_seg;
                nres                 = 2'd2;
                state_next.zcount    = '0;
                state_next.run_param  = param_down(state.run_param, RUN_DOWN);
                state_next.rice_param = rice_after;
            end
        end
        else
        begin
            seg0                  = gr_seg;
            nres                  = 2'd1;
            state_next.run_param  = (ms != '0) ? param_down(state.run_param, GR_DOWN)
                                               : param_up(state.run_param, GR_UP);
            state_next.rice_param = rice_after;
        end

        if (last)
        begin
            if (nres == 2'd2)
            begin
                seg1.final_segment = 1'b1;
            end
            else
            begin
                seg0.final_segment = 1'b1;
            end
            state_next = STATE_RESET;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rlgr1_outq.sv =====
// Three-entry segment queue between the coding step and the output channel.
// Takes up to two segments per push. Depends on rlgr1_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlgr1_outq
    import rlgr1_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [1:0]        push_n,
    input  seg_t              push_seg0,
    input  seg_t              push_seg1,
    input  logic              out_stall,
    output seg_t              head,
    output logic              head_valid,
    output logic [QCNT_W-1:0] room
);

    seg_t              q_reg  [OUTQ_DEPTH];
    seg_t              q_next [OUTQ_DEPTH];
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic [QCNT_W-1:0] count_after;
    logic              pop;

    always_comb
    begin
        pop         = (count_reg != '0) && !out_stall;
        count_after = count_reg - QCNT_W'(pop);

        for (int i = 0; i < OUTQ_DEPTH; i++)
        begin
            q_next[i] = q_reg[i];
        end
        // advance towards the head on a pop
        for (int i = 0; i < OUTQ_DEPTH - 1; i++)
        begin
            if (pop)
            begin
                q_next[i] = q_reg[i + 1];
            end
        end
        for (int i = 0; i < OUTQ_DEPTH; i++)
        begin
            if (push && (count_after == QCNT_W'(i)))
            begin
                q_next[i] = push_seg0;
            end
            if (push && (push_n == 2'd2) && ((count_after + 1'b1) == QCNT_W'(i)))
            begin
                q_next[i] = push_seg1;
            end
        end

        count_next = count_after + (push ? QCNT_W'(push_n) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign head       = q_reg[0];
    assign head_valid = (count_reg != '0);
    assign room       = QCNT_W'(OUTQ_DEPTH) - count_reg;

endmodule

`default_nettype wire

// ===== rtl/rlgr1_entropy_encoder_top.sv =====
// RLGR1 entropy encoder, top level: input register, adaptive state, coding
// step and segment queue. Depends on rlgr1_pkg, rlgr1_core, rlgr1_outq.
//
// Usage
//   Input channel (in_valid / in_stall): one signed coefficient per word with
//   a last flag marking the final coefficient of a block.
//   Output channel (out_valid / out_stall): one bit segment per word, a run of
//   run_length copies of run_bit followed by literal_length literal bits,
//   MSB first. final_segment marks the end of a block; the packer pads there.
//   A coefficient gives zero, one or two segments.
//   Path: a word accepted into the input register is coded there and its
//   segments enter the queue, whose head is offered on the output port.
//   Throughput: one coefficient per cycle while each gives at most one
//   segment and the queue has room; the output port moves one segment per
//   cycle while out_stall is low, so a two-segment coefficient (end of a
//   zero run) occupies it for both; the three-entry queue buffers them.
//   Reset: run and Rice parameters of 8, an empty zero run, input register
//   and queue empty. The same state is restored after each last word.
//   Stall: while out_stall is high the head segment holds; the queue fills,
//   then the input register holds and in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

`include "rlgr1_entropy_encoder_top_macros.svh"

module rlgr1_entropy_encoder_top
    import rlgr1_pkg::*;
#(
    parameter int COEFF_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COEFF_W-1:0] coefficient,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      run_bit,
    output logic [RUN_W-1:0]          run_length,
    output logic [LIT_W-1:0]          literal_bits,
    output logic [LLEN_W-1:0]         literal_length,
    output logic                      final_segment
);

    logic               in_valid_reg;
    logic [COEFF_W-1:0] coeff_reg;
    logic               last_reg;
    state_t             state_reg;
    state_t             state_next;
    seg_t               seg0;
    seg_t               seg1;
    seg_t               head;
    logic [1:0]         nres;
    logic [QCNT_W-1:0]  room;
    logic               commit;
    logic               accept;

    // Input register: take a new word when empty or when the held one is committed
    assign commit   = in_valid_reg && (room >= QCNT_W'(nres));
    assign in_stall = in_valid_reg && !commit;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (commit)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coeff_reg <= coefficient;
            last_reg  <= last;
        end
    end

    // Adaptive state: advance only when the coded segments enter the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (commit)
        begin
            state_reg <= state_next;
        end
    end

    rlgr1_core #(
        .COEFF_BITS (COEFF_BITS)
    ) u_core (
        .coefficient (coeff_reg),
        .last        (last_reg),
        .state       (state_reg),
        .seg0        (seg0),
        .seg1        (seg1),
        .nres        (nres),
        .state_next  (state_next)
    );

    rlgr1_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (commit),
        .push_n     (nres),
        .push_seg0  (seg0),
        .push_seg1  (seg1),
        .out_stall  (out_stall),
        .head       (head),
        .head_valid (out_valid),
        .room       (room)
    );

    assign run_bit        = head.run_bit;
    assign run_length     = head.run_length;
    assign literal_bits   = head.literal_bits;
    assign literal_length = head.literal_length;
    assign final_segment  = head.final_segment;

    // A last word always closes the block with at least one segment
    `RLGR1_ASSERT_IMP(a_last_yields, clk, rst_n, (commit && last_reg), (nres != 2'd0))
    // State is back at its reset values after a last word
    `RLGR1_ASSERT_NEXT(a_reset_after_last, clk, rst_n, (commit && last_reg), (state_reg == STATE_RESET))
    // Adaptive parameters stay within their clamp
    `RLGR1_ASSERT_IMP(a_param_range, clk, rst_n, in_valid_reg, (state_reg.run_param <= PARAM_MAX && state_reg.rice_param <= PARAM_MAX))

endmodule

`default_nettype wire
